@@ rtl/core/point_on_edge_hit_test_core_defines.svh @@
// ----------------------------------------------------------------------------
// point_on_edge_hit_test_core_defines
// assertion macros shared by the hit test core
// ----------------------------------------------------------------------------
`ifndef POINT_ON_EDGE_HIT_TEST_CORE_DEFINES_SVH
`define POINT_ON_EDGE_HIT_TEST_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define POTE_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("hit test core check failed");
// next-cycle implication, checked out of reset
`define POTE_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("hit test core check failed");
`else
`define POTE_ASSERT_NOW(lbl, pre, post)
`define POTE_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ rtl/core/pote_pkg.sv @@
// ----------------------------------------------------------------------------
// pote_pkg
// shared types and constants for the point-on-edge hit test core
// ----------------------------------------------------------------------------
package pote_pkg;

    // default sizes
    localparam int NODE_DEPTH_DEF  = 1024;
    localparam int SEG_DEPTH_DEF   = 1024;
    localparam int COORD_WIDTH_DEF = 24;

    // fixed field widths
    localparam int MODE_W = 2;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int TOL_W  = 23;
    localparam int APB_AW = 4;

    // beat kinds
    localparam logic [MODE_W-1:0] MODE_NODE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEG   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // register indexes
    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_SEG_COUNT  = 2'd1;
    localparam logic [1:0] REG_TOLERANCE  = 2'd2;

    // accumulator action
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_act;

    // control word for the multiply-accumulate unit
    typedef struct packed {
        t_acc_act   act;
        logic       neg;
        logic [1:0] shift;
    } t_mac_ctl;

    // query sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TOL,
        ST_TOL_W,
        ST_TOL_S,
        ST_SEG,
        ST_NODE,
        ST_DIFF,
        ST_AB_X,
        ST_AB_Y,
        ST_DOT_X,
        ST_DOT_Y,
        ST_DOT_W,
        ST_DECIDE,
        ST_D_X,
        ST_D_Y,
        ST_D_W,
        ST_D_CMP,
        ST_CR_X,
        ST_CR_Y,
        ST_CR_W,
        ST_CR_ABS,
        ST_WL,
        ST_WR,
        ST_WR_W,
        ST_W_CMP
    } t_state;

endpackage

@@ rtl/core/pote_mac.sv @@
// ----------------------------------------------------------------------------
// pote_mac
// shared unsigned multiplier with a registered product and a wide
// shift/add/subtract accumulator behind it
// ----------------------------------------------------------------------------
module pote_mac #(
    parameter int LIMB_W = 25
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pote_pkg::t_mac_ctl      i_ctl,
    input  logic [LIMB_W-1:0]       i_op_a,
    input  logic [LIMB_W-1:0]       i_op_b,
    output logic [4*LIMB_W:0]       o_acc
);
    import pote_pkg::*;

    localparam int ACC_W = 4 * LIMB_W + 1;

    logic [2*LIMB_W-1:0] r_prod;
    t_mac_ctl            r_ctl;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic [ACC_W-1:0]    addend;
    logic [ACC_W-1:0]    signed_add;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
        if (!i_rst_n) begin
            r_ctl <= '{act: ACC_HOLD, neg: 1'b0, shift: 2'd0};
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // limb alignment and sign
    always_comb begin
        case (r_ctl.shift)
            2'd0:    addend = ACC_W'(r_prod);
            2'd1:    addend = ACC_W'(r_prod) << LIMB_W;
            2'd2:    addend = ACC_W'(r_prod) << (2 * LIMB_W);
            default: addend = ACC_W'(r_prod);
        endcase
        signed_add = r_ctl.neg ? (~addend + ACC_W'(1)) : addend;
        case (r_ctl.act)
            ACC_LOAD: n_acc = signed_add;
            ACC_ADD:  n_acc = r_acc + signed_add;
            default:  n_acc = r_acc;
        endcase
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/core/point_on_edge_hit_test_core.sv @@
// writes (node, segment) leave busy low
// query: squares the tolerance, then walks the stored segments: one with an end
// out of range is skipped, else the nearest point is an end node or inside it;
// stops at the first hit, else finds the table end; strobe next
// the per-segment work runs on the shared multiplier of pote_mac
// sync active-low reset clears config regs and sequencer; tables keep contents
// ----------------------------------------------------------------------------
// point_on_edge_hit_test_core
// node and segment tables in block memories, queried by a sequencer that
// walks the segment table and tests point-to-segment distance exactly
// ----------------------------------------------------------------------------
`include "point_on_edge_hit_test_core_defines.svh"

module point_on_edge_hit_test_core #(
    parameter int NODE_DEPTH  = pote_pkg::NODE_DEPTH_DEF,
    parameter int SEG_DEPTH   = pote_pkg::SEG_DEPTH_DEF,
    parameter int COORD_WIDTH = pote_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pote_pkg::MODE_W-1:0]       i_mode,
    input  logic [pote_pkg::IDX_W-1:0]        i_entry_index,
    input  logic signed [COORD_WIDTH-1:0]     i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]     i_coord_y,
    input  logic [pote_pkg::IDX_W-1:0]        i_end_a,
    input  logic [pote_pkg::IDX_W-1:0]        i_end_b,
    output logic                              o_result_valid,
    output logic                              o_on_edge,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pote_pkg::APB_AW-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import pote_pkg::*;

    localparam int LIMB_W = (COORD_WIDTH + 1 > TOL_W) ? COORD_WIDTH + 1 : TOL_W;
    localparam int ACC_W  = 4 * LIMB_W + 1;
    localparam int NAW    = $clog2(NODE_DEPTH);
    localparam int SAW    = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
    localparam int SCW    = $clog2(SEG_DEPTH + 1);
    localparam int NW2    = 2 * COORD_WIDTH;
    localparam int SW2    = 2 * IDX_W;

    // difference slots
    localparam int D_ABX = 0;
    localparam int D_ABY = 1;
    localparam int D_APX = 2;
    localparam int D_APY = 3;
    localparam int D_BPX = 4;
    localparam int D_BPY = 5;

    // configuration registers
    logic [CNT_W-1:0] r_node_count;
    logic [CNT_W-1:0] r_seg_count;
    logic [TOL_W-1:0] r_tol;
    logic             cfg_wr;

    // sequencer
    t_state           r_state, n_state;
    logic [SCW-1:0]   r_idx, n_idx;
    logic [1:0]       r_pp, n_pp;
    logic             r_usebp, n_usebp;
    logic             r_res_valid, n_res_valid;
    logic             r_on_edge, n_on_edge;

    // memories and read data
    logic [NW2-1:0]   node_mem [NODE_DEPTH];
    logic [SW2-1:0]   seg_mem  [SEG_DEPTH];
    logic [NW2-1:0]   r_nd_a, r_nd_b;
    logic [SW2-1:0]   r_seg;
    logic             node_we, seg_we, node_re, seg_re;
    logic [31:0]      widx32, sa32, sb32;
    logic [NAW-1:0]   node_raddr_a, node_raddr_b;

    // datapath
    logic signed [COORD_WIDTH-1:0] r_px, r_py;
    logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
    logic signed [LIMB_W-1:0]      d_val [6];
    logic                          r_dsgn [6];
    logic [LIMB_W-1:0]             r_dmag [6];
    logic [2*LIMB_W-1:0]           r_tol2, r_ab2, r_cross;
    logic [4*LIMB_W-1:0]           r_lhs;
    logic [ACC_W-1:0]              acc, cross_mag;
    logic [LIMB_W-1:0]             op_a, op_b;
    t_mac_ctl                      mac_ctl;
    logic                          save_tol2, save_ab2, save_cross, save_lhs, save_diff;
    logic [31:0]                   nodes_eff, segs_eff;
    logic                          accept, seg_ok;
    logic                          ab2_zero, dot_np, ab2_le_dot;
    logic [1:0]                    pp_shift;

    assign accept = start & ~busy;
    assign busy   = (r_state != ST_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_seg_count  <= '0;
            r_tol        <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_NODE_COUNT: r_node_count <= pwdata[CNT_W-1:0];
                REG_SEG_COUNT:  r_seg_count  <= pwdata[CNT_W-1:0];
                REG_TOLERANCE:  r_tol        <= pwdata[TOL_W-1:0];
                default:        ;
            endcase
        end
    end

    // configuration read back
    always_comb begin
        case (paddr[3:2])
            REG_NODE_COUNT: prdata = 32'(r_node_count);
            REG_SEG_COUNT:  prdata = 32'(r_seg_count);
            REG_TOLERANCE:  prdata = 32'(r_tol);
            default:        prdata = '0;
        endcase
    end

    // counts capped at the table depths
    assign nodes_eff = (32'(r_node_count) < 32'(NODE_DEPTH)) ?
                       32'(r_node_count) : 32'(NODE_DEPTH);
    assign segs_eff  = (32'(r_seg_count) < 32'(SEG_DEPTH)) ?
                       32'(r_seg_count) : 32'(SEG_DEPTH);

    // table writes, only while idle so no read can overlap them
    assign widx32  = 32'(i_entry_index);
    assign node_we = accept && (i_mode == MODE_NODE) && (widx32 < 32'(NODE_DEPTH));
    assign seg_we  = accept && (i_mode == MODE_SEG) && (widx32 < 32'(SEG_DEPTH));

    // segment entry fields and node addresses
    assign sa32         = 32'(r_seg[SW2-1:IDX_W]);
    assign sb32         = 32'(r_seg[IDX_W-1:0]);
    assign seg_ok       = (sa32 < nodes_eff) && (sb32 < nodes_eff);
    assign node_raddr_a = sa32[NAW-1:0];
    assign node_raddr_b = sb32[NAW-1:0];

    // node table, one write port and two read ports
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[widx32[NAW-1:0]] <= {i_coord_x, i_coord_y};
        end
        if (node_re) begin
            r_nd_a <= node_mem[node_raddr_a];
            r_nd_b <= node_mem[node_raddr_b];
        end
    end

    // segment table
    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            seg_mem[widx32[SAW-1:0]] <= {i_end_a, i_end_b};
        end
        if (seg_re) begin
            r_seg <= seg_mem[r_idx[SAW-1:0]];
        end
    end

    // differences of the segment ends and the query point
    always_comb begin
        ax = r_nd_a[NW2-1:COORD_WIDTH];
        ay = r_nd_a[COORD_WIDTH-1:0];
        bx = r_nd_b[NW2-1:COORD_WIDTH];
        by = r_nd_b[COORD_WIDTH-1:0];
        d_val[D_ABX] = LIMB_W'(bx) - LIMB_W'(ax);
        d_val[D_ABY] = LIMB_W'(by) - LIMB_W'(ay);
        d_val[D_APX] = LIMB_W'(r_px) - LIMB_W'(ax);
        d_val[D_APY] = LIMB_W'(r_py) - LIMB_W'(ay);
        d_val[D_BPX] = LIMB_W'(r_px) - LIMB_W'(bx);
        d_val[D_BPY] = LIMB_W'(r_py) - LIMB_W'(by);
    end

    // decision terms from the accumulator
    assign ab2_zero   = (r_ab2 == '0);
    assign dot_np     = acc[ACC_W-1] | (acc == '0);
    assign ab2_le_dot = (ACC_W'(r_ab2) <= acc);
    assign cross_mag  = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
    assign pp_shift   = {1'b0, r_pp[0]} + {1'b0, r_pp[1]};

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept && (i_mode == MODE_QUERY)) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (save_diff) begin
            for (int k = 0; k < 6; k++) begin
                r_dsgn[k] <= d_val[k][LIMB_W-1];
                r_dmag[k] <= d_val[k][LIMB_W-1] ? LIMB_W'(-d_val[k]) : LIMB_W'(d_val[k]);
            end
        end
        if (save_tol2) begin
            r_tol2 <= acc[2*LIMB_W-1:0];
        end
        if (save_ab2) begin
            r_ab2 <= acc[2*LIMB_W-1:0];
        end
        if (save_cross) begin
            r_cross <= cross_mag[2*LIMB_W-1:0];
        end
        if (save_lhs) begin
            r_lhs <= acc[4*LIMB_W-1:0];
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_pp        <= '0;
            r_usebp     <= 1'b0;
            r_res_valid <= 1'b0;
            r_on_edge   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pp        <= n_pp;
            r_usebp     <= n_usebp;
            r_res_valid <= n_res_valid;
            r_on_edge   <= n_on_edge;
        end
    end

    // sequencer next state and multiplier schedule
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pp        = r_pp;
        n_usebp     = r_usebp;
        n_res_valid = 1'b0;
        n_on_edge   = r_on_edge;
        seg_re      = 1'b0;
        node_re     = 1'b0;
        save_tol2   = 1'b0;
        save_ab2    = 1'b0;
        save_cross  = 1'b0;
        save_lhs    = 1'b0;
        save_diff   = 1'b0;
        op_a        = '0;
        op_b        = '0;
        mac_ctl     = '{act: ACC_HOLD, neg: 1'b0, shift: 2'd0};
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_mode == MODE_QUERY)) begin
                    n_idx   = '0;
                    n_state = ST_TOL;
                end
            end
            // tolerance squared, once per query
            ST_TOL: begin
                op_a        = LIMB_W'(r_tol);
                op_b        = LIMB_W'(r_tol);
                mac_ctl.act = ACC_LOAD;
                n_state     = ST_TOL_W;
            end
            ST_TOL_W: n_state = ST_TOL_S;
            ST_TOL_S: begin
                save_tol2 = 1'b1;
                n_state   = ST_SEG;
            end
            // fetch the next segment or finish with no hit
            ST_SEG: begin
                if (32'(r_idx) < segs_eff) begin
                    seg_re  = 1'b1;
                    n_state = ST_NODE;
                end else begin
                    n_res_valid = 1'b1;
                    n_on_edge   = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            ST_NODE: begin
                if (seg_ok) begin
                    node_re = 1'b1;
                    n_state = ST_DIFF;
                end else begin
                    n_idx   = SCW'(r_idx + 1'b1);
                    n_state = ST_SEG;
                end
            end
            ST_DIFF: begin
                save_diff = 1'b1;
                n_state   = ST_AB_X;
            end
            // squared segment length
            ST_AB_X: begin
                op_a        = r_dmag[D_ABX];
                op_b        = r_dmag[D_ABX];
                mac_ctl.act = ACC_LOAD;
                n_state     = ST_AB_Y;
            end
            ST_AB_Y: begin
                op_a        = r_dmag[D_ABY];
                op_b        = r_dmag[D_ABY];
                mac_ctl.act = ACC_ADD;
                n_state     = ST_DOT_X;
            end
            // projection dot product
            ST_DOT_X: begin
                op_a        = r_dmag[D_APX];
                op_b        = r_dmag[D_ABX];
                mac_ctl.neg = r_dsgn[D_APX] ^ r_dsgn[D_ABX];
                mac_ctl.act = ACC_LOAD;
                n_state     = ST_DOT_Y;
            end
            ST_DOT_Y: begin
                save_ab2    = 1'b1;
                op_a        = r_dmag[D_APY];
                op_b        = r_dmag[D_ABY];
                mac_ctl.neg = r_dsgn[D_APY] ^ r_dsgn[D_ABY];
                mac_ctl.act = ACC_ADD;
                n_state     = ST_DOT_W;
            end
            ST_DOT_W: n_state = ST_DECIDE;
            // start node, end node or interior
            ST_DECIDE: begin
                if (ab2_zero || dot_np) begin
                    n_usebp = 1'b0;
                    n_state = ST_D_X;
                end else if (ab2_le_dot) begin
                    n_usebp = 1'b1;
                    n_state = ST_D_X;
                end else begin
                    n_state = ST_CR_X;
                end
            end
            // squared distance to one end node
            ST_D_X: begin
                op_a        = r_usebp ? r_dmag[D_BPX] : r_dmag[D_APX];
                op_b        = op_a;
                mac_ctl.act = ACC_LOAD;
                n_state     = ST_D_Y;
            end
            ST_D_Y: begin
                op_a        = r_usebp ? r_dmag[D_BPY] : r_dmag[D_APY];
                op_b        = op_a;
                mac_ctl.act = ACC_ADD;
                n_state     = ST_D_W;
            end
            ST_D_W: n_state = ST_D_CMP;
            ST_D_CMP: begin
                if (acc <= ACC_W'(r_tol2)) begin
                    n_res_valid = 1'b1;
                    n_on_edge   = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_idx   = SCW'(r_idx + 1'b1);
                    n_state = ST_SEG;
                end
            end
            // cross product
            ST_CR_X: begin
                op_a        = r_dmag[D_APX];
                op_b        = r_dmag[D_ABY];
                mac_ctl.neg = r_dsgn[D_APX] ^ r_dsgn[D_ABY];
                mac_ctl.act = ACC_LOAD;
                n_state     = ST_CR_Y;
            end
            ST_CR_Y: begin
                op_a        = r_dmag[D_APY];
                op_b        = r_dmag[D_ABX];
                mac_ctl.neg = ~(r_dsgn[D_APY] ^ r_dsgn[D_ABX]);
                mac_ctl.act = ACC_ADD;
                n_state     = ST_CR_W;
            end
            ST_CR_W: n_state = ST_CR_ABS;
            ST_CR_ABS: begin
                save_cross = 1'b1;
                n_state    = ST_WL;
            end
            // cross squared, four limb products
            ST_WL: begin
                op_a          = r_pp[0] ? r_cross[2*LIMB_W-1:LIMB_W] : r_cross[LIMB_W-1:0];
                op_b          = r_pp[1] ? r_cross[2*LIMB_W-1:LIMB_W] : r_cross[LIMB_W-1:0];
                mac_ctl.shift = pp_shift;
                mac_ctl.act   = (r_pp == 2'd0) ? ACC_LOAD : ACC_ADD;
                n_pp          = r_pp + 2'd1;
                if (r_pp == 2'd3) begin
                    n_state = ST_WR;
                end
            end
            // tolerance squared times length squared
            ST_WR: begin
                save_lhs      = (r_pp == 2'd1);
                op_a          = r_pp[0] ? r_tol2[2*LIMB_W-1:LIMB_W] : r_tol2[LIMB_W-1:0];
                op_b          = r_pp[1] ? r_ab2[2*LIMB_W-1:LIMB_W] : r_ab2[LIMB_W-1:0];
                mac_ctl.shift = pp_shift;
                mac_ctl.act   = (r_pp == 2'd0) ? ACC_LOAD : ACC_ADD;
                n_pp          = r_pp + 2'd1;
                if (r_pp == 2'd3) begin
                    n_state = ST_WR_W;
                end
            end
            ST_WR_W: n_state = ST_W_CMP;
            ST_W_CMP: begin
                if (r_lhs <= acc[4*LIMB_W-1:0]) begin
                    n_res_valid = 1'b1;
                    n_on_edge   = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_idx   = SCW'(r_idx + 1'b1);
                    n_state = ST_SEG;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // shared multiply-accumulate unit
    pote_mac #(
        .LIMB_W (LIMB_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .o_acc   (acc)
    );

    assign o_result_valid = r_res_valid;
    assign o_on_edge      = r_on_edge;

    // checks
    `POTE_ASSERT_NEXT(a_query_goes_busy, accept && (i_mode == MODE_QUERY), busy)
    `POTE_ASSERT_NOW(a_result_ends_query, o_result_valid, $past(busy))
    `POTE_ASSERT_NOW(a_limb_count_in_wide, r_pp != 2'd0, r_state == ST_WL || r_state == ST_WR)

endmodule

@@ verif/point_on_edge_hit_test_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_on_edge_hit_test_core_tb
// fills the node and segment tables, walks through several register settings
// and checks every query flag against an exact integer distance predictor
// ----------------------------------------------------------------------------
module point_on_edge_hit_test_core_tb;
    import pote_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int TABLE_DEPTH   = 1024;
    localparam int STALL_LIMIT   = 100000;
    localparam int SETTLE_BEATS  = 8;
    localparam int NODE_FILL_MAX = 32;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  idx;
        logic [23:0]       x;
        logic [23:0]       y;
        logic [IDX_W-1:0]  ea;
        logic [IDX_W-1:0]  eb;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [MODE_W-1:0] i_mode = '0;
    logic [IDX_W-1:0] i_entry_index = '0;
    logic signed [23:0] i_coord_x = '0;
    logic signed [23:0] i_coord_y = '0;
    logic [IDX_W-1:0] i_end_a = '0;
    logic [IDX_W-1:0] i_end_b = '0;
    logic o_result_valid;
    logic o_on_edge;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    point_on_edge_hit_test_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_entry_index(i_entry_index),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_end_a(i_end_a), .i_end_b(i_end_b),
        .o_result_valid(o_result_valid), .o_on_edge(o_on_edge),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of tables and registers
    longint     tab_x [TABLE_DEPTH];
    longint     tab_y [TABLE_DEPTH];
    logic [9:0] tab_a [TABLE_DEPTH];
    logic [9:0] tab_b [TABLE_DEPTH];
    int unsigned live_nodes_reg, live_segs_reg, tol_reg;

    // stimulus side bookkeeping
    t_beat   pending_beats[$];
    bit      edge_flags_due[$];
    bit      node_made [TABLE_DEPTH];
    bit      seg_made [TABLE_DEPTH];
    longint  gen_x [TABLE_DEPTH];
    longint  gen_y [TABLE_DEPTH];
    logic [IDX_W-1:0] gen_ea [TABLE_DEPTH];
    logic [IDX_W-1:0] gen_eb [TABLE_DEPTH];
    bit      no_gaps = 1'b0;
    int      failures = 0;
    int      stall_cycles = 0;

    // squared distance test against one segment, exact in wide integers
    function automatic bit near_edge(longint px, longint py, longint ax, longint ay,
                                     longint bx, longint by, t_wide tol2);
        t_wide abx, aby, apx, apy, bpx, bpy, ab2, dot, cr;
        abx = t_wide'(bx - ax);
        aby = t_wide'(by - ay);
        apx = t_wide'(px - ax);
        apy = t_wide'(py - ay);
        bpx = t_wide'(px - bx);
        bpy = t_wide'(py - by);
        ab2 = abx * abx + aby * aby;
        dot = apx * abx + apy * aby;
        if (ab2 == 0 || dot <= 0)
            return (apx * apx + apy * apy) <= tol2;
        if (ab2 <= dot)
            return (bpx * bpx + bpy * bpy) <= tol2;
        cr = apx * aby - apy * abx;
        if (cr < 0)
            cr = -cr;
        return (cr * cr) <= tol2 * ab2;
    endfunction

    // flag for a query point over all live segments
    function automatic bit point_hits_any_edge(longint px, longint py);
        int unsigned nodes, segs;
        t_wide tol2;
        nodes = live_nodes_reg < TABLE_DEPTH ? live_nodes_reg : TABLE_DEPTH;
        segs  = live_segs_reg < TABLE_DEPTH ? live_segs_reg : TABLE_DEPTH;
        tol2  = t_wide'(tol_reg) * t_wide'(tol_reg);
        for (int i = 0; i < segs; i++) begin
            if (tab_a[i] < nodes && tab_b[i] < nodes &&
                near_edge(px, py, tab_x[tab_a[i]], tab_y[tab_a[i]],
                          tab_x[tab_b[i]], tab_y[tab_b[i]], tol2))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // driver: apply the accepted beat to the predictor, then offer the next
    always @(posedge i_clk) begin
        bit    go;
        t_beat nb;
        if (i_rst_n) begin
            go = start;
            if (start && !busy) begin
                go = 1'b0;
                case (i_mode)
                    MODE_NODE: begin
                        tab_x[i_entry_index] = longint'(i_coord_x);
                        tab_y[i_entry_index] = longint'(i_coord_y);
                    end
                    MODE_SEG: begin
                        tab_a[i_entry_index] = i_end_a;
                        tab_b[i_entry_index] = i_end_b;
                    end
                    MODE_QUERY: edge_flags_due = {edge_flags_due,
                        point_hits_any_edge(longint'(i_coord_x), longint'(i_coord_y))};
                    default: ;
                endcase
            end
            if (!go && pending_beats.size() > 0 && (no_gaps || $urandom_range(99) >= 33)) begin
                nb = pending_beats.pop_front();
                i_mode        <= nb.mode;
                i_entry_index <= nb.idx;
                i_coord_x     <= nb.x;
                i_coord_y     <= nb.y;
                i_end_a       <= nb.ea;
                i_end_b       <= nb.eb;
                go = 1'b1;
            end
            start <= go;
        end
    end

    // monitor: compare each flag beat with the oldest expectation
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_result_valid) begin
            if (edge_flags_due.size() == 0) begin
                $error("on_edge beat with nothing expected, actual %0b", o_on_edge);
                failures++;
            end else begin
                want = edge_flags_due.pop_front();
                if (o_on_edge !== want) begin
                    $error("on_edge mismatch: expected %0b actual %0b", want, o_on_edge);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat or result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_result_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("point_on_edge_hit_test_core test failed");
                $finish;
            end
        end
    end

    task automatic apb_write(logic [1:0] reg_idx, int unsigned value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_NODE_COUNT: live_nodes_reg = value & 32'h7FF;
            REG_SEG_COUNT:  live_segs_reg  = value & 32'h7FF;
            default:        tol_reg        = value & 32'h7FFFFF;
        endcase
    endtask

    // block idle: nothing queued, nothing in flight, then a short settle
    task automatic wait_idle();
        while (pending_beats.size() > 0 || start || edge_flags_due.size() > 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_BEATS) @(posedge i_clk);
    endtask

    task automatic queue_beat(logic [1:0] mode, int idx, longint x, longint y,
                              int ea, int eb);
        t_beat b;
        b.mode = mode;
        b.idx  = IDX_W'(idx);
        b.x    = x[23:0];
        b.y    = y[23:0];
        b.ea   = IDX_W'(ea);
        b.eb   = IDX_W'(eb);
        if (mode == MODE_NODE) begin
            node_made[b.idx] = 1'b1;
            gen_x[b.idx] = longint'(signed'(b.x));
            gen_y[b.idx] = longint'(signed'(b.y));
        end
        if (mode == MODE_SEG) begin
            seg_made[b.idx] = 1'b1;
            gen_ea[b.idx]   = b.ea;
            gen_eb[b.idx]   = b.eb;
        end
        pending_beats = {pending_beats, b};
    endtask

    function automatic longint rand_coord(bit wide_spread);
        if (wide_spread)
            return longint'(signed'(24'($urandom())));
        return longint'($urandom_range(0, 8192)) - 4096;
    endfunction

    // end node index: out of the live range, or a node that holds data
    function automatic int pick_end(int nlive, int nfill);
        int e;
        if ($urandom_range(99) < 20)
            e = $urandom_range(0, 1023);
        else
            e = $urandom_range(0, nfill + 2 > 1023 ? 1023 : nfill + 2);
        if (e < nlive && !node_made[e[9:0]])
            e = $urandom_range(0, nfill - 1);
        return e;
    endfunction

    function automatic int pick_entry(int nlive);
        if ($urandom_range(99) < 30)
            return $urandom_range(0, 1023);
        return $urandom_range(0, nlive > 1023 ? 1023 : nlive);
    endfunction

    // live segment whose ends are either skipped or hold node data
    function automatic bit seg_ends_ready(int i, int nlive);
        return (int'(gen_ea[i]) >= nlive || node_made[gen_ea[i]]) &&
               (int'(gen_eb[i]) >= nlive || node_made[gen_eb[i]]);
    endfunction

    // one register setting followed by random traffic
    task automatic run_phase(int n, int s, int tol, int beats, bit wide_spread, bit calm);
        int nlive, slive, nfill, r, j;
        longint spread;
        wait_idle();
        apb_write(REG_NODE_COUNT, n);
        apb_write(REG_SEG_COUNT, s);
        apb_write(REG_TOLERANCE, tol);
        no_gaps = calm;
        nlive = n > TABLE_DEPTH ? TABLE_DEPTH : n;
        slive = s > TABLE_DEPTH ? TABLE_DEPTH : s;
        nfill = nlive > NODE_FILL_MAX ? NODE_FILL_MAX : nlive;
        // every entry a query can read holds written data before any query
        for (int i = 0; i < nfill; i++)
            if (!node_made[i])
                queue_beat(MODE_NODE, i, rand_coord(wide_spread), rand_coord(wide_spread), 0, 0);
        for (int i = 0; i < slive; i++)
            if (!seg_made[i] || !seg_ends_ready(i, nlive))
                queue_beat(MODE_SEG, i, 0, 0, pick_end(nlive, nfill), pick_end(nlive, nfill));
        spread = 2 * longint'(tol) + 16;
        repeat (beats) begin
            r = $urandom_range(99);
            if (r < 45) begin
                if (nfill > 0 && $urandom_range(99) < 70) begin
                    j = $urandom_range(0, nfill - 1);
                    queue_beat(MODE_QUERY, $urandom_range(0, 1023),
                               gen_x[j] + longint'($urandom_range(0, 2 * spread)) - spread,
                               gen_y[j] + longint'($urandom_range(0, 2 * spread)) - spread,
                               $urandom_range(0, 1023), $urandom_range(0, 1023));
                end else begin
                    queue_beat(MODE_QUERY, $urandom_range(0, 1023), rand_coord(wide_spread),
                               rand_coord(wide_spread), $urandom_range(0, 1023),
                               $urandom_range(0, 1023));
                end
            end else if (r < 70) begin
                queue_beat(MODE_NODE, pick_entry(nlive), rand_coord(wide_spread),
                           rand_coord(wide_spread), $urandom_range(0, 1023),
                           $urandom_range(0, 1023));
            end else if (r < 95) begin
                queue_beat(MODE_SEG, pick_entry(nlive), rand_coord(1), rand_coord(1),
                           pick_end(nlive, nfill), pick_end(nlive, nfill));
            end else begin
                queue_beat(MODE_UNUSED, $urandom_range(0, 1023), rand_coord(1), rand_coord(1),
                           $urandom_range(0, 1023), $urandom_range(0, 1023));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme nodes, a zero-length segment, a bad segment
        run_phase(4, 4, 0, 0, 0, 0);
        queue_beat(MODE_NODE, 0, 8388607, 8388607, 0, 0);
        queue_beat(MODE_NODE, 1, -8388608, -8388608, 0, 0);
        queue_beat(MODE_NODE, 2, 0, 0, 0, 0);
        queue_beat(MODE_NODE, 3, 256, 0, 0, 0);
        queue_beat(MODE_NODE, 1023, -8388608, 8388607, 1023, 1023);
        queue_beat(MODE_SEG, 0, 0, 0, 0, 1);
        queue_beat(MODE_SEG, 1, 0, 0, 2, 2);
        queue_beat(MODE_SEG, 2, 0, 0, 2, 3);
        queue_beat(MODE_SEG, 3, 0, 0, 1023, 0);
        queue_beat(MODE_QUERY, 0, 0, 0, 0, 0);
        queue_beat(MODE_QUERY, 0, 128, 0, 0, 0);
        queue_beat(MODE_QUERY, 0, 128, 1, 0, 0);
        queue_beat(MODE_QUERY, 0, -1, 0, 0, 0);
        queue_beat(MODE_QUERY, 0, 257, 0, 0, 0);
        queue_beat(MODE_QUERY, 1023, 8388607, 8388607, 1023, 1023);
        queue_beat(MODE_QUERY, 0, -8388608, -8388608, 0, 0);
        queue_beat(MODE_UNUSED, 1023, -1, -1, 1023, 1023);
        run_phase(4, 4, 1, 0, 0, 0);
        queue_beat(MODE_QUERY, 0, 128, 1, 0, 0);
        queue_beat(MODE_QUERY, 0, -1, 0, 0, 0);
        queue_beat(MODE_QUERY, 0, 258, 0, 0, 0);
        queue_beat(MODE_QUERY, 0, 100, -2, 0, 0);

        // random part, most phases on small tables
        run_phase(0, 0, 500, 20, 0, 0);
        run_phase(6, 0, 500, 20, 0, 0);
        run_phase(0, 6, 500, 20, 0, 0);
        run_phase(8, 4, 256, 70, 0, 0);
        run_phase(16, 8, 2048, 70, 0, 1);
        run_phase(12, 10, 0, 60, 0, 0);
        run_phase(10, 6, 8388607, 60, 1, 0);
        run_phase(20, 16, 1500000, 60, 1, 0);
        run_phase(2047, 12, 8388607, 16, 1, 0);
        run_phase(1024, 12, 4096, 60, 0, 0);
        run_phase(5, 3, 300, 60, 0, 0);

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (failures == 0)
            $display("point_on_edge_hit_test_core test passed");
        else
            $display("point_on_edge_hit_test_core test failed");
        $finish;
    end
endmodule
